// File: rtl/core/event_flag_group_unit_defines.svh
// ----------------------------------------------------------------------------
// Event flag group unit: assertion macros
// Shared assertion helpers for the event flag group RTL.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_UNIT_DEFINES_SVH
`define EVENT_FLAG_GROUP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define EFG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define EFG_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`else

`define EFG_ASSERT(lbl, clk, rstn, prop, msg)

`define EFG_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// File: rtl/core/efg_pkg.sv
// ----------------------------------------------------------------------------
// Event flag group package
// Codes, field widths and controller/datapath bundles of the unit.
// ----------------------------------------------------------------------------
package efg_pkg;

    localparam int DATA_W = 32;
    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 4;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_WAIT    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_DELETE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 4'd0,
        ST_AGAIN   = 4'd1,
        ST_ISR     = 4'd2,
        ST_LOCKED  = 4'd3,
        ST_IDLE    = 4'd4,
        ST_QUEUED  = 4'd5,
        ST_TIMEOUT = 4'd6,
        ST_FULL    = 4'd7,
        ST_DELETED = 4'd8
    } t_status;

    localparam logic [1:0] CTX_TASK   = 2'd0;
    localparam logic [1:0] CTX_ISR    = 2'd1;
    localparam logic [1:0] CTX_LOCKED = 2'd2;
    localparam logic [1:0] CTX_IDLE   = 2'd3;

    typedef enum logic [1:0] {
        OUT_SLOT = 2'd0,
        OUT_SUM  = 2'd1,
        OUT_ONE  = 2'd2
    } t_out_kind;

    typedef struct packed {
        logic      in_ready;
        logic      scan_run;
        logic      idx_clr;
        logic      idx_inc;
        logic      rd_en;
        logic      free_take;
        logic      set_full;
        logic      out_load;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic accept;
        t_op  in_op;
        logic in_queue;
        t_op  cur_op;
        logic scan_done;
        logic free_hit;
        logic free_last;
        logic idx_end;
        logic woke_cur;
        logic found;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/efg_chan_if.sv
// ----------------------------------------------------------------------------
// Event flag group channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface efg_in_if;
    import efg_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [DATA_W-1:0] flag_bits;
    logic [DATA_W-1:0] set_mask;
    logic              wait_all;
    logic              clear_on_exit;
    logic              no_wait;
    logic [1:0]        caller_context;
    logic [ID_W-1:0]   waiter_id;
    logic [PRIO_W-1:0] waiter_prio;
    logic [PRIO_W-1:0] running_prio;

    modport source (
        output valid, opcode, flag_bits, set_mask, wait_all, clear_on_exit, no_wait,
        output caller_context, waiter_id, waiter_prio, running_prio,
        input  ready
    );

    modport sink (
        input  valid, opcode, flag_bits, set_mask, wait_all, clear_on_exit, no_wait,
        input  caller_context, waiter_id, waiter_prio, running_prio,
        output ready
    );
endinterface

interface efg_out_if;
    import efg_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   result_id;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] result_bits;
    logic [DATA_W-1:0] flags_now;
    logic              preempt;
    logic              last;

    modport source (
        output valid, result_id, status, result_bits, flags_now, preempt, last,
        input  ready
    );

    modport sink (
        input  valid, result_id, status, result_bits, flags_now, preempt, last,
        output ready
    );
endinterface

// File: rtl/core/efg_datapath.sv
// ----------------------------------------------------------------------------
// Event flag group datapath
// Flag word, waiter slot store, scan pipeline and result register.
// ----------------------------------------------------------------------------
`include "event_flag_group_unit_defines.svh"

module efg_datapath #(
    parameter int FLAG_WIDTH   = 32,
    parameter int WAITER_SLOTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    efg_in_if.sink        i_in,
    efg_out_if.source     o_out,
    input  efg_pkg::t_cmd i_cmd,
    output efg_pkg::t_stat o_stat
);
    import efg_pkg::*;

    localparam int IW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CW = $clog2(WAITER_SLOTS + 1);
    localparam logic [CW-1:0] LastIdx = CW'(WAITER_SLOTS - 1);
    localparam logic [CW-1:0] EndIdx  = CW'(WAITER_SLOTS);

    function automatic logic [FLAG_WIDTH-1:0] f_match(
        input logic [FLAG_WIDTH-1:0] flags,
        input logic [FLAG_WIDTH-1:0] wanted,
        input logic                  all_mode
    );
        logic [FLAG_WIDTH-1:0] hit;
        hit = flags & wanted;
        if (all_mode && (hit != wanted)) begin
            hit = '0;
        end
        return hit;
    endfunction

    logic [FLAG_WIDTH-1:0]   r_flag;
    logic [WAITER_SLOTS-1:0] r_valid;
    logic [WAITER_SLOTS-1:0] r_woke;
    logic [CW-1:0]           r_idx;
    logic [IW-1:0]           r_idx_d;
    logic                    r_ph1;

    t_op                     r_op;
    logic [FLAG_WIDTH-1:0]   r_bits;
    logic                    r_all;
    logic                    r_coe;
    logic [ID_W-1:0]         r_wid;
    logic [PRIO_W-1:0]       r_wprio;
    logic [PRIO_W-1:0]       r_rprio;
    t_status                 r_status;
    logic [FLAG_WIDTH-1:0]   r_wbits;
    logic [FLAG_WIDTH-1:0]   r_clr;
    logic                    r_sched;
    logic                    r_found;

    logic [FLAG_WIDTH-1:0]   mem_wanted [WAITER_SLOTS];
    logic [1:0]              mem_opt    [WAITER_SLOTS];
    logic [ID_W-1:0]         mem_id     [WAITER_SLOTS];
    logic [PRIO_W-1:0]       mem_prio   [WAITER_SLOTS];
    logic [FLAG_WIDTH-1:0]   r_rd_wanted;
    logic [1:0]              r_rd_opt;
    logic [ID_W-1:0]         r_rd_id;
    logic [PRIO_W-1:0]       r_rd_prio;

    logic                    r_out_valid;
    logic [ID_W-1:0]         r_out_id;
    t_status                 r_out_status;
    logic [DATA_W-1:0]       r_out_bits;
    logic [DATA_W-1:0]       r_out_flags;
    logic                    r_out_pre;
    logic                    r_out_last;

    logic                    w_accept;
    t_op                     w_in_op;
    logic [FLAG_WIDTH-1:0]   w_in_bits;
    logic [FLAG_WIDTH-1:0]   w_in_mask;
    logic [FLAG_WIDTH-1:0]   w_in_match;
    t_status                 w_in_status;
    logic                    w_in_queue;
    logic [IW-1:0]           w_idx_a;
    logic                    w_scan_rd;
    logic                    w_re;
    logic [FLAG_WIDTH-1:0]   w_slot_match;
    logic                    w_slot_pre;
    logic                    w_slot_hit;
    logic [FLAG_WIDTH-1:0]   w_flags_now;
    logic                    w_out_free;

    assign w_accept   = i_in.valid && i_cmd.in_ready;
    assign w_in_op    = t_op'(i_in.opcode);
    assign w_in_bits  = FLAG_WIDTH'(i_in.flag_bits);
    assign w_in_mask  = FLAG_WIDTH'(i_in.set_mask);
    assign w_in_match = f_match(r_flag, w_in_bits, i_in.wait_all);
    assign w_idx_a    = r_idx[IW-1:0];
    assign w_scan_rd  = i_cmd.scan_run && (r_idx != EndIdx);
    assign w_re       = w_scan_rd || i_cmd.rd_en;
    assign w_flags_now = r_flag & ~r_clr;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = i_cmd.in_ready;

    always_comb begin
        w_in_queue = 1'b0;
        if (w_in_match != '0) begin
            w_in_status = ST_OK;
        end else if (i_in.no_wait) begin
            w_in_status = ST_AGAIN;
        end else if (i_in.caller_context == CTX_ISR) begin
            w_in_status = ST_ISR;
        end else if (i_in.caller_context == CTX_LOCKED) begin
            w_in_status = ST_LOCKED;
        end else if (i_in.caller_context == CTX_IDLE) begin
            w_in_status = ST_IDLE;
        end else begin
            w_in_status = ST_QUEUED;
            w_in_queue  = (w_in_op == OP_WAIT);
        end
    end

    assign w_slot_match = f_match(r_flag, r_rd_wanted, r_rd_opt[0]);
    assign w_slot_pre   = r_rd_prio > r_rprio;

    always_comb begin
        case (r_op)
            OP_SEND:    w_slot_hit = r_valid[r_idx_d] && (w_slot_match != '0);
            OP_DELETE:  w_slot_hit = r_valid[r_idx_d];
            OP_TIMEOUT: w_slot_hit = r_valid[r_idx_d] && (r_rd_id == r_wid);
            default:    w_slot_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_ph1       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ph1 <= w_scan_rd;
            if (w_accept) begin
                case (w_in_op)
                    OP_SEND: begin
                        r_flag <= r_flag ^ ((r_flag ^ w_in_bits) & w_in_mask);
                    end
                    OP_DELETE: begin
                        r_flag <= '0;
                    end
                    OP_WAIT: begin
                        if (i_in.clear_on_exit) begin
                            r_flag <= r_flag & ~w_in_match;
                        end
                    end
                    default: begin
                        r_flag <= r_flag;
                    end
                endcase
            end else if (i_cmd.out_load && (i_cmd.out_kind == OUT_SUM)) begin
                r_flag <= w_flags_now;
            end
            if (w_accept || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc || w_scan_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_ph1 && w_slot_hit) begin
                r_valid[r_idx_d] <= 1'b0;
            end
            if (i_cmd.free_take) begin
                r_valid[w_idx_a] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_d <= w_idx_a;
        if (w_accept) begin
            r_op     <= w_in_op;
            r_bits   <= w_in_bits;
            r_all    <= i_in.wait_all;
            r_coe    <= i_in.clear_on_exit;
            r_wid    <= i_in.waiter_id;
            r_wprio  <= i_in.waiter_prio;
            r_rprio  <= i_in.running_prio;
            r_clr    <= '0;
            r_sched  <= 1'b0;
            r_woke   <= '0;
            r_found  <= 1'b0;
            r_wbits  <= (w_in_op == OP_WAIT) ? w_in_match : '0;
            case (w_in_op)
                OP_WAIT:    r_status <= w_in_status;
                OP_TIMEOUT: r_status <= ST_TIMEOUT;
                default:    r_status <= ST_OK;
            endcase
        end else begin
            if (r_ph1 && w_slot_hit) begin
                if (r_op == OP_TIMEOUT) begin
                    r_found <= 1'b1;
                end else begin
                    r_woke[r_idx_d] <= 1'b1;
                    r_sched         <= r_sched || w_slot_pre;
                end
                if ((r_op == OP_SEND) && r_rd_opt[1]) begin
                    r_clr <= r_clr | w_slot_match;
                end
            end
            if (i_cmd.set_full) begin
                r_status <= ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.free_take) begin
            mem_wanted[w_idx_a] <= r_bits;
            mem_opt[w_idx_a]    <= {r_coe, r_all};
            mem_id[w_idx_a]     <= r_wid;
            mem_prio[w_idx_a]   <= r_wprio;
        end
        if (w_re) begin
            r_rd_wanted <= mem_wanted[w_idx_a];
            r_rd_opt    <= mem_opt[w_idx_a];
            r_rd_id     <= mem_id[w_idx_a];
            r_rd_prio   <= mem_prio[w_idx_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                OUT_SLOT: begin
                    r_out_id     <= r_rd_id;
                    r_out_status <= (r_op == OP_DELETE) ? ST_DELETED : ST_OK;
                    r_out_bits   <= (r_op == OP_SEND) ? DATA_W'(w_slot_match) : '0;
                    r_out_flags  <= DATA_W'(w_flags_now);
                    r_out_pre    <= w_slot_pre;
                    r_out_last   <= 1'b0;
                end
                OUT_SUM: begin
                    r_out_id     <= '0;
                    r_out_status <= ST_OK;
                    r_out_bits   <= '0;
                    r_out_flags  <= DATA_W'(w_flags_now);
                    r_out_pre    <= r_sched;
                    r_out_last   <= 1'b1;
                end
                default: begin
                    r_out_id     <= r_wid;
                    r_out_status <= r_status;
                    r_out_bits   <= DATA_W'(r_wbits);
                    r_out_flags  <= DATA_W'(r_flag);
                    r_out_pre    <= 1'b0;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_id   = r_out_id;
    assign o_out.status      = r_out_status;
    assign o_out.result_bits = r_out_bits;
    assign o_out.flags_now   = r_out_flags;
    assign o_out.preempt     = r_out_pre;
    assign o_out.last        = r_out_last;

    always_comb begin
        o_stat.accept    = w_accept;
        o_stat.in_op     = w_in_op;
        o_stat.in_queue  = w_in_queue;
        o_stat.cur_op    = r_op;
        o_stat.scan_done = (r_idx == EndIdx) && !r_ph1;
        o_stat.free_hit  = !r_valid[w_idx_a];
        o_stat.free_last = (r_idx == LastIdx);
        o_stat.idx_end   = (r_idx == EndIdx);
        o_stat.woke_cur  = r_woke[w_idx_a];
        o_stat.found     = r_found;
        o_stat.out_free  = w_out_free;
    end

    `EFG_ASSERT(a_load_free, i_clk, i_rst_n, !i_cmd.out_load || w_out_free, "result loaded over a pending transfer")
    `EFG_ASSERT(a_accept_quiet, i_clk, i_rst_n, !w_accept || !r_ph1, "item accepted during a slot scan")
    `EFG_ASSERT(a_take_free, i_clk, i_rst_n, !i_cmd.free_take || !r_valid[w_idx_a], "occupied slot taken by a wait")
    `EFG_ASSERT_NEXT(a_sum_clear, i_clk, i_rst_n, i_cmd.out_load && (i_cmd.out_kind == OUT_SUM), (r_flag & r_clr) == '0, "claimed bits left in the flag word")

endmodule

// File: rtl/core/efg_ctrl.sv
// ----------------------------------------------------------------------------
// Event flag group controller
// Sequences accept, slot scan, result emission and slot allocation.
// ----------------------------------------------------------------------------
module efg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  efg_pkg::t_stat i_stat,
    output efg_pkg::t_cmd  o_cmd
);
    import efg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_FREE  = 7'b0000100,
        S_EADDR = 7'b0001000,
        S_EDATA = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_ONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.accept) begin
                    if (i_stat.in_op != OP_WAIT) begin
                        n_state = S_SCAN;
                    end else if (i_stat.in_queue) begin
                        n_state = S_FREE;
                    end else begin
                        n_state = S_ONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.idx_clr = 1'b1;
                    if (i_stat.cur_op != OP_TIMEOUT) begin
                        n_state = S_EADDR;
                    end else if (i_stat.found) begin
                        n_state = S_ONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FREE: begin
                if (i_stat.free_hit) begin
                    o_cmd.free_take = 1'b1;
                    n_state         = S_ONE;
                end else if (i_stat.free_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_ONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EADDR: begin
                if (i_stat.idx_end) begin
                    n_state = S_SUM;
                end else if (i_stat.woke_cur) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_EDATA;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EDATA: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_SLOT;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = S_EADDR;
                end
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_SUM;
                    n_state        = S_IDLE;
                end
            end
            S_ONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = OUT_ONE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/event_flag_group_unit.sv
// ----------------------------------------------------------------------------
// Event flag group unit
// Flag word with a table of waiter slots: send, wait, timeout and delete.
// ----------------------------------------------------------------------------
//   Channel | Direction | Payload
//   i_in    | in        | opcode, flag bits, mask, wait options, id, priorities
//   o_out   | out       | result id, status, bits, flags now, preempt, last
//
// With N slots and W woken waiters, a send or delete runs through the accept,
// a scan of all N slots, an emission pass with one result per woken waiter
// and the summary. A timeout gives one result only if a waiter matches; a wait
// gives one, after a free-slot search if it queues. No reset pass clears the slots.
// A stall on o_out holds the emission; a new item is taken while the last
// result still waits in the output register.
module event_flag_group_unit #(
    parameter int FLAG_WIDTH   = 32,
    parameter int WAITER_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efg_in_if.sink    i_in,
    efg_out_if.source o_out
);
    import efg_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    efg_datapath #(
        .FLAG_WIDTH   (FLAG_WIDTH),
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    efg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

endmodule
